// ----- design/stable_priority_queue_unit_macros.svh -----
// Assertion macros for the stable priority queue unit.
// Each check is sampled on clk_i. Defining ASSERT_OFF removes all checks.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while rst_ni is high.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked during reset as well.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- design/spq_pkg.sv -----
package spq_pkg;

  localparam int unsigned PrioW  = 3;
  localparam int unsigned TagW   = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned RcntW  = 5;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdCall   = 1'b1;

  localparam logic [StatW-1:0] StOk    = 2'd0;
  localparam logic [StatW-1:0] StEmpty = 2'd1;
  localparam logic [StatW-1:0] StFull  = 2'd2;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [TagW-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic call;
  } cell_ctrl_t;

endpackage

// ----- design/spq_cell.sv -----
module spq_cell (
  input  logic              clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic              occ_i,
  input  logic              left_keep_i,
  input  spq_pkg::entry_t   new_i,
  input  spq_pkg::entry_t   left_i,
  input  spq_pkg::entry_t   right_i,
  output logic              keep_o,
  output spq_pkg::entry_t   entry_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // An occupied cell whose priority does not exceed the new one stays put.
  assign keep_o = occ_i && (entry_q.prio <= new_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (!keep_o) begin
        entry_d = left_keep_i ? new_i : left_i;
      end
    end else if (ctrl_i.call) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- design/stable_priority_queue_unit.sv -----
// Stable priority queue. Holds up to QUEUE_DEPTH entries (priority, tag) in a
// row of cells kept sorted by priority, head in cell 0; lower numbers leave
// first and equal priorities leave in arrival order. A request with command
// insert places its entry after every held entry of lower or equal priority;
// a full queue drops it and reports status full. A request with command call
// removes the head and returns its tag and priority; an empty queue reports
// status empty with zero tag and priority. Every request gives exactly one
// result carrying the entry count left after it (low five bits). Throughput
// is one request per cycle while the output is not stalled: every cell
// compares its priority with the new one in parallel and loads from itself,
// its left neighbor, the new entry or its right neighbor in a single pass,
// and the result sits in an output register that accepts the next request
// whenever it is empty or being drained. Priority bits above PRIORITY_BITS
// are ignored. Stored entries need no clearing after reset; only cells below
// the entry count are ever read.
`include "stable_priority_queue_unit_macros.svh"

module stable_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PRIORITY_BITS = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [spq_pkg::PrioW-1:0]    priority_req_i,
  input  logic [spq_pkg::TagW-1:0]     entry_tag_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [spq_pkg::StatW-1:0]    status_o,
  output logic [spq_pkg::TagW-1:0]     called_tag_o,
  output logic [spq_pkg::PrioW-1:0]    called_priority_o,
  output logic [spq_pkg::RcntW-1:0]    remaining_count_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PrioW-1:0] PrioMask =
    (PRIORITY_BITS >= PrioW) ? {PrioW{1'b1}} : PrioW'((1 << PRIORITY_BITS) - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

  logic [CntW-1:0] count_q, count_d;
  logic            accept;
  logic            is_full, is_empty;
  logic            do_ins, do_call;
  cell_ctrl_t      ctrl;
  entry_t          new_entry;
  entry_t          cell_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keep;

  logic             out_valid_q;
  logic [StatW-1:0] status_q, status_d;
  logic [TagW-1:0]  tag_q, tag_d;
  logic [PrioW-1:0] prio_q, prio_d;
  logic [CntW+RcntW-1:0] cnt_ext;
  logic [RcntW-1:0] rcnt_q;

  // Take a new request whenever the result register is free or draining.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_full  = (count_q == DepthCnt);
  assign is_empty = (count_q == '0);
  assign do_ins   = accept && (command_i == CmdInsert) && !is_full;
  assign do_call  = accept && (command_i == CmdCall) && !is_empty;

  assign ctrl.ins  = do_ins;
  assign ctrl.call = do_call;

  assign new_entry.prio = priority_req_i & PrioMask;
  assign new_entry.tag  = entry_tag_i;

  // Row of cells: each one holds, shifts right or takes the new entry on insert, shifts left on call.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   occ;
    logic   left_keep;
    entry_t left_entry;
    entry_t right_entry;

    assign occ = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_body
      assign left_keep  = keep[i-1];
      assign left_entry = cell_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = cell_q[i];
    end else begin : g_inner
      assign right_entry = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ),
      .left_keep_i (left_keep),
      .new_i       (new_entry),
      .left_i      (left_entry),
      .right_i     (right_entry),
      .keep_o      (keep[i]),
      .entry_o     (cell_q[i])
    );
  end

  // Count after this request; full and empty cases leave it unchanged.
  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + 1'b1;
    end else if (do_call) begin
      count_d = count_q - 1'b1;
    end
  end

  // Build the result of the request.
  always_comb begin
    status_d = StOk;
    tag_d    = '0;
    prio_d   = '0;
    if (command_i == CmdInsert) begin
      if (is_full) begin
        status_d = StFull;
      end
    end else if (is_empty) begin
      status_d = StEmpty;
    end else begin
      tag_d  = cell_q[0].tag;
      prio_d = cell_q[0].prio;
    end
  end

  assign cnt_ext = {{RcntW{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until the next request is taken.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      tag_q    <= tag_d;
      prio_q   <= prio_d;
      rcnt_q   <= cnt_ext[RcntW-1:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign called_tag_o      = tag_q;
  assign called_priority_o = prio_q;
  assign remaining_count_o = rcnt_q;

  `SPQ_ASSERT(a_count_bound, count_q <= DepthCnt, "entry count exceeds queue depth")
  `SPQ_ASSERT(a_ins_grows, do_ins |=> (count_q == CntW'($past(count_q) + 1'b1)), "insert did not grow count")
  `SPQ_ASSERT(a_call_shrinks, do_call |=> (count_q == CntW'($past(count_q) - 1'b1)), "call did not shrink count")
  `SPQ_ASSERT(a_head_sorted, (count_q >= CntW'(2)) |-> (cell_q[0].prio <= cell_q[1].prio), "head cells out of order")
  `SPQ_ASSERT_ALWAYS(a_stall_needs_valid, in_stall_o |-> out_valid_q, "input stalled with empty result register")

endmodule
